>>> sv/dual_stream_rate_estimator_assert.svh
// Assertion macros for the dual stream rate estimator.
`ifndef DUAL_STREAM_RATE_ESTIMATOR_ASSERT_SVH
`define DUAL_STREAM_RATE_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define DSRE_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define DSRE_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/dsre_pkg.sv
// Package: shared constants and types of the dual stream rate estimator.
package dsre_pkg;

   localparam int STAMP_BITS_DEF = 48;
   localparam int AVG_BITS_DEF   = 24;

   localparam int W_BITS    = 16;   // EMA weight, Q16
   localparam int GAP_BITS  = 24;   // gap limit and usable interval width
   localparam int CNT_BITS  = 32;
   localparam int RATE_BITS = 32;

   // 1000 Hz*ms scaled by 1024 (stamp units) and 256 (rate units)
   localparam int                 RATE_NUM_BITS = 28;
   localparam logic [RATE_NUM_BITS-1:0] RATE_NUM = 28'd262144000;

   localparam logic [W_BITS:0] ONE_Q = {1'b1, {W_BITS{1'b0}}};

   localparam logic [W_BITS-1:0]   EMA_WEIGHT_RST = 16'd6554;
   localparam logic [GAP_BITS-1:0] GAP_LIMIT_RST  = 24'd1024000;

   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 24;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EMA_WEIGHT = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GAP_LIMIT  = 1'd1;

   typedef struct packed {
      logic                pos;     // new stamp strictly after the reference
      logic                ge_gap;  // interval at or above the gap limit
      logic [GAP_BITS-1:0] dt;      // low bits of the interval
   } sub_result_type;

endpackage

>>> sv/dual_stream_rate_estimator.sv
// Dual stream rate estimator: per-source sample counts and EMA-based sample rates.
//
// Requests arrive on req_* (valid/stall) carrying one gyro or accel sample with its
// timestamp in 1/1024 ms. A request with req_sample_ok low is taken and
// dropped. Every other request yields one response on rsp_* with the sequence number,
// both per-source totals and both rates in 1/256 Hz (0 while a source has no average).
// One request is processed at a time; req_stall is high while it is in flight.
// A bad stamp or the first stamp of its source goes straight to the output register.
// Otherwise a bit-serial subtract runs over the stamp bits and ends the request when the
// stamp is not newer; an interval that reaches the gap limit clears the average and rate,
// the first interval seeds the average, and a later one updates it through the serial
// multiply-accumulate; a nonzero average then goes through the serial divide.
// Only the rate of the source just updated is divided again; the other is cached.
// Results sit in an output register: the next request is accepted while a response
// waits, but a finished update holds in its last state until the register is free.
// A stalled response keeps its payload. Synchronous reset clears the control state and counts
// and loads the default weight and gap limit; csr_* writes go in at any idle cycle.
`include "dual_stream_rate_estimator_assert.svh"

module dual_stream_rate_estimator #(
   parameter int STAMP_BITS = dsre_pkg::STAMP_BITS_DEF,
   parameter int AVG_BITS   = dsre_pkg::AVG_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_sample_ok,
   input  logic                                req_is_gyro,
   input  logic                                req_stamp_ok,
   input  logic [STAMP_BITS-1:0]               req_stamp,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_source_gyro,
   output logic [dsre_pkg::CNT_BITS-1:0]       rsp_sample_number,
   output logic [dsre_pkg::CNT_BITS-1:0]       rsp_gyro_total,
   output logic [dsre_pkg::CNT_BITS-1:0]       rsp_accel_total,
   output logic [dsre_pkg::RATE_BITS-1:0]      rsp_gyro_rate,
   output logic [dsre_pkg::RATE_BITS-1:0]      rsp_accel_rate,

   input  logic                                csr_write_en,
   input  logic [dsre_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [dsre_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import dsre_pkg::*;

   localparam int MUL_BITS = (GAP_BITS > AVG_BITS) ? GAP_BITS : AVG_BITS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SUB  = 3'd1;
   localparam logic [2:0] S_EMA  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   // control and state
   logic [2:0]            state_ff,       state_in;
   logic [STAMP_BITS-1:0] gyro_last_ff,   gyro_last_in;
   logic [STAMP_BITS-1:0] accel_last_ff,  accel_last_in;
   logic                  gyro_ref_ff,    gyro_ref_in;
   logic                  accel_ref_ff,   accel_ref_in;
   logic [AVG_BITS-1:0]   gyro_avg_ff,    gyro_avg_in;
   logic [AVG_BITS-1:0]   accel_avg_ff,   accel_avg_in;
   logic [RATE_BITS-1:0]  gyro_rate_ff,   gyro_rate_in;
   logic [RATE_BITS-1:0]  accel_rate_ff,  accel_rate_in;
   logic [CNT_BITS-1:0]   gyro_count_ff,  gyro_count_in;
   logic [CNT_BITS-1:0]   accel_count_ff, accel_count_in;
   logic [CNT_BITS-1:0]   seq_count_ff,   seq_count_in;
   logic [W_BITS-1:0]     ema_weight_ff,  ema_weight_in;
   logic [GAP_BITS-1:0]   gap_limit_ff,   gap_limit_in;
   logic                  rsp_valid_ff,   rsp_valid_in;

   // payload
   logic [STAMP_BITS-1:0] stamp_ff;
   logic                  cur_gyro_ff;
   logic                  rsp_source_gyro_ff;
   logic [CNT_BITS-1:0]   rsp_sample_number_ff;
   logic [CNT_BITS-1:0]   rsp_gyro_total_ff;
   logic [CNT_BITS-1:0]   rsp_accel_total_ff;
   logic [RATE_BITS-1:0]  rsp_gyro_rate_ff;
   logic [RATE_BITS-1:0]  rsp_accel_rate_ff;

   logic                  req_accept;
   logic                  rsp_load;
   logic [AVG_BITS-1:0]   cur_avg;

   logic                  sub_start;
   logic [STAMP_BITS-1:0] sub_ref;
   logic                  sub_done;
   sub_result_type        sub_res;

   logic                  ema_start;
   logic                  ema_done;
   logic [AVG_BITS-1:0]   ema_avg;

   logic                  div_start;
   logic                  div_done;
   logic [RATE_BITS-1:0]  div_q;

   logic                  avg_wr;
   logic [AVG_BITS-1:0]   avg_val;
   logic [MUL_BITS-1:0]   dt_wide;
   logic [AVG_BITS-1:0]   dt_sat;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign rsp_load   = (state_ff == S_OUT) && (~rsp_valid_ff || ~rsp_stall);
   assign cur_avg    = cur_gyro_ff ? gyro_avg_ff : accel_avg_ff;
   assign sub_ref    = req_is_gyro ? gyro_last_ff : accel_last_ff;

   // first interval seeds the average directly, clipped to its width
   assign dt_wide = MUL_BITS'(sub_res.dt);
   assign dt_sat  = (dt_wide > MUL_BITS'({AVG_BITS{1'b1}})) ? '1 : dt_wide[AVG_BITS-1:0];

   dsre_bit_sub #(
      .STAMP_BITS (STAMP_BITS)
   ) u_sub (
      .clock      (clock),
      .reset      (reset),
      .start      (sub_start),
      .minuend    (req_stamp),
      .subtrahend (sub_ref),
      .gap_limit  (gap_limit_ff),
      .done       (sub_done),
      .result     (sub_res)
   );

   dsre_ema_mac #(
      .AVG_BITS (AVG_BITS)
   ) u_ema (
      .clock   (clock),
      .reset   (reset),
      .start   (ema_start),
      .weight  (ema_weight_ff),
      .dt      (sub_res.dt),
      .avg     (cur_avg),
      .done    (ema_done),
      .avg_new (ema_avg)
   );

   dsre_rate_div #(
      .AVG_BITS (AVG_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (avg_val),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in       = state_ff;
      gyro_last_in   = gyro_last_ff;
      accel_last_in  = accel_last_ff;
      gyro_ref_in    = gyro_ref_ff;
      accel_ref_in   = accel_ref_ff;
      gyro_avg_in    = gyro_avg_ff;
      accel_avg_in   = accel_avg_ff;
      gyro_rate_in   = gyro_rate_ff;
      accel_rate_in  = accel_rate_ff;
      gyro_count_in  = gyro_count_ff;
      accel_count_in = accel_count_ff;
      seq_count_in   = seq_count_ff;
      ema_weight_in  = ema_weight_ff;
      gap_limit_in   = gap_limit_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      sub_start      = 1'b0;
      ema_start      = 1'b0;
      div_start      = 1'b0;
      avg_wr         = 1'b0;
      avg_val        = '0;

      if (csr_write_en) begin
         case (csr_index)
            CSR_EMA_WEIGHT: ema_weight_in = csr_data[W_BITS-1:0];
            CSR_GAP_LIMIT:  gap_limit_in  = csr_data[GAP_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept && req_sample_ok) begin
               seq_count_in = seq_count_ff + 1'b1;
               if (req_is_gyro) begin
                  gyro_count_in = gyro_count_ff + 1'b1;
               end else begin
                  accel_count_in = accel_count_ff + 1'b1;
               end
               state_in = S_OUT;
               if (req_stamp_ok) begin
                  if (req_is_gyro && !gyro_ref_ff) begin
                     gyro_last_in = req_stamp;
                     gyro_ref_in  = 1'b1;
                  end else if (!req_is_gyro && !accel_ref_ff) begin
                     accel_last_in = req_stamp;
                     accel_ref_in  = 1'b1;
                  end else begin
                     sub_start = 1'b1;
                     state_in  = S_SUB;
                  end
               end
            end
         end
         S_SUB: begin
            if (sub_done) begin
               if (!sub_res.pos) begin
                  state_in = S_OUT;
               end else begin
                  if (cur_gyro_ff) begin
                     gyro_last_in = stamp_ff;
                  end else begin
                     accel_last_in = stamp_ff;
                  end
                  if (sub_res.ge_gap) begin
                     avg_wr  = 1'b1;
                     avg_val = '0;
                  end else if (cur_avg == '0) begin
                     avg_wr  = 1'b1;
                     avg_val = dt_sat;
                  end else begin
                     ema_start = 1'b1;
                     state_in  = S_EMA;
                  end
               end
            end
         end
         S_EMA: begin
            if (ema_done) begin
               avg_wr  = 1'b1;
               avg_val = ema_avg;
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (cur_gyro_ff) begin
                  gyro_rate_in = div_q;
               end else begin
                  accel_rate_in = div_q;
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // new average: a zero one has rate zero, anything else goes to the divider
      if (avg_wr) begin
         if (cur_gyro_ff) begin
            gyro_avg_in = avg_val;
         end else begin
            accel_avg_in = avg_val;
         end
         if (avg_val == '0) begin
            if (cur_gyro_ff) begin
               gyro_rate_in = '0;
            end else begin
               accel_rate_in = '0;
            end
            state_in = S_OUT;
         end else begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         gyro_last_ff   <= '0;
         accel_last_ff  <= '0;
         gyro_ref_ff    <= 1'b0;
         accel_ref_ff   <= 1'b0;
         gyro_avg_ff    <= '0;
         accel_avg_ff   <= '0;
         gyro_rate_ff   <= '0;
         accel_rate_ff  <= '0;
         gyro_count_ff  <= '0;
         accel_count_ff <= '0;
         seq_count_ff   <= '0;
         ema_weight_ff  <= EMA_WEIGHT_RST;
         gap_limit_ff   <= GAP_LIMIT_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         gyro_last_ff   <= gyro_last_in;
         accel_last_ff  <= accel_last_in;
         gyro_ref_ff    <= gyro_ref_in;
         accel_ref_ff   <= accel_ref_in;
         gyro_avg_ff    <= gyro_avg_in;
         accel_avg_ff   <= accel_avg_in;
         gyro_rate_ff   <= gyro_rate_in;
         accel_rate_ff  <= accel_rate_in;
         gyro_count_ff  <= gyro_count_in;
         accel_count_ff <= accel_count_in;
         seq_count_ff   <= seq_count_in;
         ema_weight_ff  <= ema_weight_in;
         gap_limit_ff   <= gap_limit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stamp_ff    <= req_stamp;
         cur_gyro_ff <= req_is_gyro;
      end
      if (rsp_load) begin
         rsp_source_gyro_ff   <= cur_gyro_ff;
         rsp_sample_number_ff <= seq_count_ff;
         rsp_gyro_total_ff    <= gyro_count_ff;
         rsp_accel_total_ff   <= accel_count_ff;
         rsp_gyro_rate_ff     <= gyro_rate_ff;
         rsp_accel_rate_ff    <= accel_rate_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_source_gyro   = rsp_source_gyro_ff;
   assign rsp_sample_number = rsp_sample_number_ff;
   assign rsp_gyro_total    = rsp_gyro_total_ff;
   assign rsp_accel_total   = rsp_accel_total_ff;
   assign rsp_gyro_rate     = rsp_gyro_rate_ff;
   assign rsp_accel_rate    = rsp_accel_rate_ff;

   `DSRE_ASSERT_NOW(a_sub_done_in_sub, sub_done, state_ff == S_SUB, "interval done outside SUB")
   `DSRE_ASSERT_NOW(a_ema_done_in_ema, ema_done, state_ff == S_EMA, "average done outside EMA")
   `DSRE_ASSERT_NOW(a_div_done_in_div, div_done, state_ff == S_DIV, "divide done outside DIV")
   `DSRE_ASSERT_NEXT(a_seq_step, req_accept && req_sample_ok, seq_count_ff == $past(seq_count_ff) + CNT_BITS'(1), "sequence number did not advance")

endmodule

>>> sv/dsre_bit_sub.sv
// Bit-serial interval unit: stamp minus reference, compared against the gap limit.
module dsre_bit_sub #(
   parameter int STAMP_BITS = dsre_pkg::STAMP_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [STAMP_BITS-1:0]         minuend,
   input  logic [STAMP_BITS-1:0]         subtrahend,
   input  logic [dsre_pkg::GAP_BITS-1:0] gap_limit,
   output logic                          done,
   output dsre_pkg::sub_result_type      result
);
   import dsre_pkg::*;

   localparam int CNT_W = $clog2(STAMP_BITS);

   logic [STAMP_BITS-1:0] a_ff;
   logic [STAMP_BITS-1:0] b_ff;
   logic [STAMP_BITS-1:0] g_ff;
   logic                  br_ff;
   logic                  gbr_ff;
   logic                  nz_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   logic d_bit;
   logic br_in;
   logic gbr_in;
   logic last_step;

   always_comb begin
      d_bit  = a_ff[0] ^ b_ff[0] ^ br_ff;
      br_in  = (~a_ff[0] & b_ff[0]) | (~(a_ff[0] ^ b_ff[0]) & br_ff);
      // running compare of the difference bits against the gap limit
      gbr_in = (~d_bit & g_ff[0]) | (~(d_bit ^ g_ff[0]) & gbr_ff);
      last_step = busy_ff && (cnt_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= last_step;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (last_step) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // difference bits shift into the top of the minuend register
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= minuend;
         b_ff   <= subtrahend;
         g_ff   <= STAMP_BITS'(gap_limit);
         br_ff  <= 1'b0;
         gbr_ff <= 1'b0;
         nz_ff  <= 1'b0;
         cnt_ff <= CNT_W'(STAMP_BITS - 1);
      end else if (busy_ff) begin
         a_ff   <= {d_bit, a_ff[STAMP_BITS-1:1]};
         b_ff   <= {1'b0, b_ff[STAMP_BITS-1:1]};
         g_ff   <= {1'b0, g_ff[STAMP_BITS-1:1]};
         br_ff  <= br_in;
         gbr_ff <= gbr_in;
         nz_ff  <= nz_ff | d_bit;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done          = done_ff;
   assign result.pos    = ~br_ff & nz_ff;
   assign result.ge_gap = ~gbr_ff;
   assign result.dt     = a_ff[GAP_BITS-1:0];

endmodule

>>> sv/dsre_ema_mac.sv
// Serial multiply-accumulate for the moving average, one weight bit per cycle.
module dsre_ema_mac #(
   parameter int AVG_BITS = dsre_pkg::AVG_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dsre_pkg::W_BITS-1:0]   weight,
   input  logic [dsre_pkg::GAP_BITS-1:0] dt,
   input  logic [AVG_BITS-1:0]           avg,
   output logic                          done,
   output logic [AVG_BITS-1:0]           avg_new
);
   import dsre_pkg::*;

   localparam int MUL_BITS = (GAP_BITS > AVG_BITS) ? GAP_BITS : AVG_BITS;
   localparam int ACC_BITS = MUL_BITS + W_BITS + 2;
   localparam int STEPS    = W_BITS + 1;
   localparam int CNT_W    = $clog2(STEPS);
   localparam int SH_BITS  = ACC_BITS - W_BITS;

   logic [W_BITS:0]       w_ff;
   logic [W_BITS:0]       c_ff;
   logic [MUL_BITS-1:0]   dt_ff;
   logic [MUL_BITS-1:0]   av_ff;
   logic [ACC_BITS-1:0]   acc_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   logic [ACC_BITS-1:0]   add_w;
   logic [ACC_BITS-1:0]   add_c;
   logic [ACC_BITS-1:0]   acc_in;
   logic [SH_BITS-1:0]    shifted;
   logic                  last_step;

   // MSB first: acc = 2*acc + w[i]*dt + (1-w)[i]*avg
   always_comb begin
      add_w     = w_ff[W_BITS] ? ACC_BITS'(dt_ff) : '0;
      add_c     = c_ff[W_BITS] ? ACC_BITS'(av_ff) : '0;
      acc_in    = {acc_ff[ACC_BITS-2:0], 1'b0} + add_w + add_c;
      shifted   = acc_ff[ACC_BITS-1:W_BITS];
      last_step = busy_ff && (cnt_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= last_step;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (last_step) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         w_ff   <= {1'b0, weight};
         c_ff   <= ONE_Q - {1'b0, weight};
         dt_ff  <= MUL_BITS'(dt);
         av_ff  <= MUL_BITS'(avg);
         acc_ff <= '0;
         cnt_ff <= CNT_W'(STEPS - 1);
      end else if (busy_ff) begin
         w_ff   <= {w_ff[W_BITS-1:0], 1'b0};
         c_ff   <= {c_ff[W_BITS-1:0], 1'b0};
         acc_ff <= acc_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done    = done_ff;
   assign avg_new = (|shifted[SH_BITS-1:AVG_BITS]) ? '1 : shifted[AVG_BITS-1:0];

endmodule

>>> sv/dsre_rate_div.sv
// Restoring bit-serial divider: rate constant over the average interval.
module dsre_rate_div #(
   parameter int AVG_BITS = dsre_pkg::AVG_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [AVG_BITS-1:0]            divisor,
   output logic                           done,
   output logic [dsre_pkg::RATE_BITS-1:0] quotient
);
   import dsre_pkg::*;

   localparam int CNT_W = $clog2(RATE_NUM_BITS);

   logic [RATE_NUM_BITS-1:0] n_ff;
   logic [RATE_NUM_BITS-1:0] q_ff;
   logic [AVG_BITS-1:0]      r_ff;
   logic [AVG_BITS-1:0]      d_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     busy_ff;
   logic                     done_ff;

   logic [AVG_BITS:0]        trial;
   logic [AVG_BITS:0]        diff;
   logic                     fits;
   logic [AVG_BITS-1:0]      r_in;
   logic                     last_step;

   always_comb begin
      trial     = {r_ff, n_ff[RATE_NUM_BITS-1]};
      diff      = trial - {1'b0, d_ff};
      fits      = trial >= {1'b0, d_ff};
      r_in      = fits ? diff[AVG_BITS-1:0] : trial[AVG_BITS-1:0];
      last_step = busy_ff && (cnt_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= last_step;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (last_step) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff   <= RATE_NUM;
         q_ff   <= '0;
         r_ff   <= '0;
         d_ff   <= divisor;
         cnt_ff <= CNT_W'(RATE_NUM_BITS - 1);
      end else if (busy_ff) begin
         n_ff   <= {n_ff[RATE_NUM_BITS-2:0], 1'b0};
         q_ff   <= {q_ff[RATE_NUM_BITS-2:0], fits};
         r_ff   <= r_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // quotient never exceeds the numerator, so it always fits the rate field
   assign done     = done_ff;
   assign quotient = RATE_BITS'(q_ff);

endmodule

>>> verif/dual_stream_rate_estimator_test.sv
// Self-checking testbench of the dual stream rate estimator: directed table, then random phases.
module dual_stream_rate_estimator_test;
   import dsre_pkg::*;

   localparam int          STAMP_W       = STAMP_BITS_DEF;
   localparam int          AVG_W         = AVG_BITS_DEF;
   localparam int          DRAIN_CYCLES  = 200;
   localparam int unsigned RUN_LIMIT     = 1000000;
   localparam logic [STAMP_W-1:0] STAMP_ONES = {STAMP_W{1'b1}};
   localparam logic [63:0]        AVG_CEIL   = (64'd1 << AVG_W) - 64'd1;

   typedef struct packed {
      logic               sample_ok;
      logic               is_gyro;
      logic               stamp_ok;
      logic [STAMP_W-1:0] stamp;
   } imu_sample_type;

   typedef struct packed {
      logic                 source_gyro;
      logic [CNT_BITS-1:0]  sample_number;
      logic [CNT_BITS-1:0]  gyro_total;
      logic [CNT_BITS-1:0]  accel_total;
      logic [RATE_BITS-1:0] gyro_rate;
      logic [RATE_BITS-1:0] accel_rate;
   } rate_report_type;

   typedef struct packed {
      logic               has_ref;
      logic [STAMP_W-1:0] last;
      logic [AVG_W-1:0]   avg;
   } interval_track_type;

   typedef struct packed {
      logic               sample_ok;
      logic               is_gyro;
      logic               stamp_ok;
      logic [STAMP_W-1:0] stamp;
      logic               typed;
      rate_report_type    want;
   } directed_row_type;

   localparam rate_report_type NO_REPORT = '0;
   localparam int DIRECTED_ROWS = 17;
   // typed rows assume the reset weight and gap limit
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{1'b0, 1'b1, 1'b1, STAMP_ONES, 1'b0, NO_REPORT},                       // dropped
      '{1'b1, 1'b1, 1'b1, 48'd0, 1'b1, '{1'b1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0}},
      '{1'b1, 1'b0, 1'b0, STAMP_ONES, 1'b1, '{1'b0, 32'd2, 32'd1, 32'd1, 32'd0, 32'd0}},
      '{1'b1, 1'b0, 1'b1, STAMP_ONES, 1'b1, '{1'b0, 32'd3, 32'd1, 32'd2, 32'd0, 32'd0}},
      '{1'b1, 1'b1, 1'b1, 48'd1024, 1'b1,
        '{1'b1, 32'd4, 32'd2, 32'd2, 32'd256000, 32'd0}},
      '{1'b1, 1'b1, 1'b1, 48'd1024, 1'b1,                                    // repeated stamp
        '{1'b1, 32'd5, 32'd3, 32'd2, 32'd256000, 32'd0}},
      '{1'b1, 1'b1, 1'b1, 48'd500, 1'b1,                                     // out of order
        '{1'b1, 32'd6, 32'd4, 32'd2, 32'd256000, 32'd0}},
      '{1'b1, 1'b1, 1'b1, 48'd2048, 1'b0, NO_REPORT},
      '{1'b1, 1'b1, 1'b1, 48'd2049, 1'b0, NO_REPORT},
      '{1'b1, 1'b1, 1'b1, 48'd1026049, 1'b1,                                 // gap clears
        '{1'b1, 32'd9, 32'd7, 32'd2, 32'd0, 32'd0}},
      '{1'b1, 1'b1, 1'b1, 48'd2050048, 1'b0, NO_REPORT},                     // just under gap
      '{1'b1, 1'b1, 1'b0, 48'd0, 1'b0, NO_REPORT},
      '{1'b1, 1'b0, 1'b1, 48'd0, 1'b0, NO_REPORT},
      '{1'b0, 1'b0, 1'b0, 48'd0, 1'b0, NO_REPORT},
      '{1'b1, 1'b0, 1'b1, STAMP_ONES, 1'b0, NO_REPORT},
      '{1'b1, 1'b1, 1'b1, 48'd2050049, 1'b0, NO_REPORT},
      '{1'b1, 1'b1, 1'b1, 48'd18827264, 1'b0, NO_REPORT}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid     = 1'b0;
   logic                     req_stall;
   logic                     req_sample_ok = 1'b0;
   logic                     req_is_gyro   = 1'b0;
   logic                     req_stamp_ok  = 1'b0;
   logic [STAMP_W-1:0]       req_stamp     = '0;

   logic                     rsp_valid;
   logic                     rsp_stall     = 1'b0;
   logic                     rsp_source_gyro;
   logic [CNT_BITS-1:0]      rsp_sample_number;
   logic [CNT_BITS-1:0]      rsp_gyro_total;
   logic [CNT_BITS-1:0]      rsp_accel_total;
   logic [RATE_BITS-1:0]     rsp_gyro_rate;
   logic [RATE_BITS-1:0]     rsp_accel_rate;

   logic                     csr_write_en  = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index     = CSR_EMA_WEIGHT;
   logic [CSR_DATA_BITS-1:0] csr_data      = '0;

   dual_stream_rate_estimator DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_ok     (req_sample_ok),
      .req_is_gyro       (req_is_gyro),
      .req_stamp_ok      (req_stamp_ok),
      .req_stamp         (req_stamp),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_source_gyro   (rsp_source_gyro),
      .rsp_sample_number (rsp_sample_number),
      .rsp_gyro_total    (rsp_gyro_total),
      .rsp_accel_total   (rsp_accel_total),
      .rsp_gyro_rate     (rsp_gyro_rate),
      .rsp_accel_rate    (rsp_accel_rate),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // predictor state and its copy of the registers
   logic [W_BITS-1:0]   ema_weight = EMA_WEIGHT_RST;
   logic [GAP_BITS-1:0] gap_limit  = GAP_LIMIT_RST;
   interval_track_type  gyro_track  = '0;
   interval_track_type  accel_track = '0;
   logic [CNT_BITS-1:0] gyro_count  = '0;
   logic [CNT_BITS-1:0] accel_count = '0;
   logic [CNT_BITS-1:0] seq_count   = '0;

   rate_report_type pending_reports[$];
   int              mismatch_count = 0;
   bit              quiet = 1'b0;
   int              stall_hold = 0;
   int unsigned     cycle_count = 0;
   rate_report_type got;

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == RUN_LIMIT) begin
         $display("dual_stream_rate_estimator_test NOT OK");
         $finish;
      end
   end

   function automatic interval_track_type next_track(interval_track_type t,
                                                     logic [STAMP_W-1:0] stamp);
      interval_track_type n;
      logic [STAMP_W-1:0] dt;
      logic [63:0] mix;
      n = t;
      if (!t.has_ref) begin
         n.has_ref = 1'b1;
         n.last = stamp;
         return n;
      end
      if (stamp <= t.last) return n;
      dt = stamp - t.last;
      n.last = stamp;
      if (dt >= STAMP_W'(gap_limit)) n.avg = '0;
      else if (t.avg == '0) n.avg = dt[AVG_W-1:0];
      else begin
         mix = (64'(ema_weight) * 64'(dt) + (64'(ONE_Q) - 64'(ema_weight)) * 64'(t.avg)) >> 16;
         n.avg = (mix > AVG_CEIL) ? AVG_CEIL[AVG_W-1:0] : mix[AVG_W-1:0];
      end
      return n;
   endfunction

   function automatic logic [RATE_BITS-1:0] rate_from_avg(logic [AVG_W-1:0] avg);
      logic [63:0] q;
      if (avg == '0) return '0;
      q = 64'(RATE_NUM) / 64'(avg);
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[RATE_BITS-1:0];
   endfunction

   function automatic rate_report_type apply_sample(imu_sample_type s);
      rate_report_type r;
      r = '0;
      if (!s.sample_ok) return r;
      if (s.stamp_ok) begin
         if (s.is_gyro) gyro_track = next_track(gyro_track, s.stamp);
         else accel_track = next_track(accel_track, s.stamp);
      end
      if (s.is_gyro) gyro_count++;
      else accel_count++;
      seq_count++;
      r.source_gyro   = s.is_gyro;
      r.sample_number = seq_count;
      r.gyro_total    = gyro_count;
      r.accel_total   = accel_count;
      r.gyro_rate     = rate_from_avg(gyro_track.avg);
      r.accel_rate    = rate_from_avg(accel_track.avg);
      return r;
   endfunction

   // mostly short, now and then long
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 150);
   endfunction

   always @(posedge clock) begin
      if (stall_hold > 0) stall_hold--;
      else begin
         rsp_stall <= !quiet && ($urandom_range(0, 2) == 0);
         stall_hold = pick_idle();
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, seen);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         got = '{rsp_source_gyro, rsp_sample_number, rsp_gyro_total, rsp_accel_total,
                 rsp_gyro_rate, rsp_accel_rate};
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected response, sample_number %0d", $time, rsp_sample_number);
            mismatch_count++;
         end else begin
            rate_report_type want;
            want = pending_reports.pop_front();
            check_field("source_gyro", 32'(want.source_gyro), 32'(got.source_gyro));
            check_field("sample_number", want.sample_number, got.sample_number);
            check_field("gyro_total", want.gyro_total, got.gyro_total);
            check_field("accel_total", want.accel_total, got.accel_total);
            check_field("gyro_rate", want.gyro_rate, got.gyro_rate);
            check_field("accel_rate", want.accel_rate, got.accel_rate);
         end
      end
   end

   task automatic send_sample(input imu_sample_type s, input bit typed,
                              input rate_report_type typed_want);
      int idle;
      rate_report_type due;
      idle = pick_idle();
      if (idle != 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_ok <= s.sample_ok;
      req_is_gyro   <= s.is_gyro;
      req_stamp_ok  <= s.stamp_ok;
      req_stamp     <= s.stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      due = apply_sample(s);
      if (s.sample_ok) pending_reports.push_back(typed ? typed_want : due);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      // dropped requests leave no response to wait for
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input logic [W_BITS-1:0] w, input logic [GAP_BITS-1:0] g);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_EMA_WEIGHT;
      csr_data     <= CSR_DATA_BITS'(w);
      @(posedge clock);
      csr_index    <= CSR_GAP_LIMIT;
      csr_data     <= CSR_DATA_BITS'(g);
      @(posedge clock);
      csr_write_en <= 1'b0;
      ema_weight = w;
      gap_limit  = g;
   endtask

   // mostly regular intervals around the period, the rest repeats, reorders and gaps
   function automatic imu_sample_type random_sample(int unsigned period);
      imu_sample_type s;
      logic [STAMP_W-1:0] ref_stamp;
      int unsigned jit;
      s.sample_ok = ($urandom_range(0, 9) != 0);
      s.is_gyro   = 1'($urandom_range(0, 1));
      s.stamp_ok  = ($urandom_range(0, 11) != 0);
      ref_stamp = s.is_gyro ? gyro_track.last : accel_track.last;
      jit = period / 8 + 1;
      case ($urandom_range(0, 31))
         0: s.stamp = {16'($urandom), 32'($urandom)};
         1: s.stamp = ref_stamp;
         2: s.stamp = ref_stamp - STAMP_W'($urandom_range(1, 5000));
         3: s.stamp = ref_stamp + STAMP_W'(gap_limit);
         4: s.stamp = ref_stamp + STAMP_W'(gap_limit) + STAMP_W'($urandom_range(1, 100000));
         5: s.stamp = ref_stamp + STAMP_W'(gap_limit) - 48'd1;
         6: s.stamp = ref_stamp + STAMP_W'($urandom_range(1, 24'hFF_FFFF));
         default: s.stamp = ref_stamp + STAMP_W'(period) + STAMP_W'($urandom_range(0, jit))
                            - STAMP_W'(jit / 2);
      endcase
      return s;
   endfunction

   task automatic run_phase(input logic [W_BITS-1:0] w, input logic [GAP_BITS-1:0] g,
                            input int reports, input bit calm);
      int made;
      int unsigned period;
      imu_sample_type s;
      drain_results();
      load_settings(w, g);
      quiet = calm;
      period = $urandom_range(500, 20000);
      made = 0;
      while (made < reports) begin
         s = random_sample(period);
         send_sample(s, 1'b0, NO_REPORT);
         if (s.sample_ok) made++;
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_sample('{DIRECTED[i].sample_ok, DIRECTED[i].is_gyro, DIRECTED[i].stamp_ok,
                       DIRECTED[i].stamp}, DIRECTED[i].typed, DIRECTED[i].want);

      run_phase(16'hFFFF, 24'hFF_FFFF, 80, 1'b0);
      run_phase(16'd0, 24'd20000, 70, 1'b0);
      run_phase(16'd1, 24'd0, 60, 1'b1);
      run_phase(16'd32768, 24'd1, 50, 1'b0);
      run_phase(16'($urandom_range(1, 65535)), 24'($urandom_range(5000, 24'hFF_FFFF)),
                120, 1'b0);
      run_phase(EMA_WEIGHT_RST, GAP_LIMIT_RST, 120, 1'b0);

      drain_results();
      if (mismatch_count == 0) begin
         $display("dual_stream_rate_estimator_test OK");
      end else begin
         $display("dual_stream_rate_estimator_test NOT OK");
      end
      $finish;
   end

endmodule
